// ===== rtl/core/dad_pkg.sv =====
// Package for the date_add_days block: state encoding, status codes,
// calendar constants and the month and year length functions.
// No dependencies.
package dad_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned OFF_W   = 17;
    localparam int unsigned ACC_W   = 18;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned CYC_W   = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [CYC_W-1:0]   YEAR_CYCLE = 9'd400;
    localparam logic [CYC_W-1:0]   CYCLE_LAST = 9'd399;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_DATE = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_CHECK,
        S_DOY,
        S_YEAR,
        S_MON,
        S_OUT
    } state_t;

    // Control from the sequencer to the year-in-cycle tracker.
    typedef struct packed {
        logic             load;
        logic             inc;
        logic             dec;
        logic [CYC_W-1:0] load_val;
    } yr_ctl_t;

    // Leap flag from the year's position within the 400-year cycle.
    function automatic logic leap_of(input logic [CYC_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [DOY_W-1:0] year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

endpackage

// ===== rtl/core/dad_if.sv =====
// Handshake interfaces for the date_add_days block: the input date item
// and the result item. Depends on dad_pkg.
interface dad_date_if
    import dad_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  in_year;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic [OFF_W-1:0]   offset;

    modport source (output valid, output in_year, output in_month, output in_day,
                    output offset, input ready);
    modport sink   (input valid, input in_year, input in_month, input in_day,
                    input offset, output ready);
endinterface

interface dad_result_if
    import dad_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [DOY_W-1:0]   day_of_year;
    logic [STAT_W-1:0]  status;

    modport source (output valid, output out_year, output out_month, output out_day,
                    output day_of_year, output status, input ready);
    modport sink   (input valid, input out_year, input out_month, input out_day,
                    input day_of_year, input status, output ready);
endinterface

// ===== rtl/core/dad_alu.sv =====
// Shared signed adder of the date_add_days block; the accumulator's arithmetic
// updates go through it, while the loads of year and day bypass it. Depends on dad_pkg.
module dad_alu
    import dad_pkg::*;
(
    input  logic signed [ACC_W-1:0] a,
    input  logic signed [ACC_W-1:0] b,
    output logic signed [ACC_W-1:0] sum
);

    assign sum = a + b;

endmodule

// ===== rtl/core/dad_leap.sv =====
// Tracks the working year's position within the 400-year Gregorian cycle
// and derives leap flags for it and for the year before. Depends on dad_pkg.
module dad_leap
    import dad_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  yr_ctl_t ctl,
    output logic    leap_cur,
    output logic    leap_prev
);

    logic [CYC_W-1:0] pos_reg;
    logic [CYC_W-1:0] pos_next;
    logic [CYC_W-1:0] pos_dec;
    logic [CYC_W-1:0] pos_inc;

    assign pos_dec = (pos_reg == '0) ? CYCLE_LAST : pos_reg - 9'd1;
    assign pos_inc = (pos_reg == CYCLE_LAST) ? '0 : pos_reg + 9'd1;

    always_comb
    begin
        priority if (ctl.load)
        begin
            pos_next = ctl.load_val;
        end
        else if (ctl.inc)
        begin
            pos_next = pos_inc;
        end
        else if (ctl.dec)
        begin
            pos_next = pos_dec;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign leap_cur  = leap_of(pos_reg);
    assign leap_prev = leap_of(pos_dec);

endmodule

// ===== rtl/core/date_add_days.sv =====
// Steps from accepted item to result valid: the year is reduced modulo 400, the date is
// checked, the months before the start are summed, whole years are walked and then
// months. One item at a time: a new item is accepted only in idle, after the result has
// been taken.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle; no result pending.
// Depends on dad_pkg, dad_if, dad_alu and dad_leap.
module date_add_days
    import dad_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    dad_date_if.sink            dates,
    dad_result_if.source        results
);

    // Sequencer and working registers.
    state_t                   state_reg, state_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [YEAR_W-1:0]        year_reg, year_next;
    logic [MONTH_W-1:0]       mon_reg, mon_next;

    // Captured input item.
    logic [YEAR_W-1:0]        iy_reg, iy_next;
    logic [MONTH_W-1:0]       im_reg, im_next;
    logic [DAY_W-1:0]         id_reg, id_next;
    logic [OFF_W-1:0]         off_reg, off_next;

    // Result item, held until taken.
    logic [YEAR_W-1:0]        oy_reg, oy_next;
    logic [MONTH_W-1:0]       om_reg, om_next;
    logic [DAY_W-1:0]         od_reg, od_next;
    logic [DOY_W-1:0]         doy_reg, doy_next;
    logic [STAT_W-1:0]        st_reg, st_next;

    // Shared adder and leap tracker hookup.
    logic signed [ACC_W-1:0]  op_b;
    logic signed [ACC_W-1:0]  sum;
    yr_ctl_t                  yctl;
    logic                     leap_cur;
    logic                     leap_prev;

    logic [DAY_W-1:0]         mlen;
    logic signed [ACC_W-1:0]  ylen_cur;
    logic signed [ACC_W-1:0]  ylen_prev;
    logic                     bad_date;

    dad_alu u_alu (
        .a   (acc_reg),
        .b   (op_b),
        .sum (sum)
    );

    dad_leap u_leap (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (yctl),
        .leap_cur  (leap_cur),
        .leap_prev (leap_prev)
    );

    // Length of the month under the counter, in the working year.
    assign mlen      = month_len(mon_reg, leap_cur);
    assign ylen_cur  = $signed({9'd0, year_len(leap_cur)});
    assign ylen_prev = $signed({9'd0, year_len(leap_prev)});

    // The tracker has been loaded with the input year's position in the cycle by the time this is used.
    assign bad_date = (iy_reg < YEAR_MIN) || (iy_reg > YEAR_MAX) ||
                      (im_reg < MONTH_FIRST) || (im_reg > MONTH_LAST) ||
                      (id_reg == '0) || (id_reg > month_len(im_reg, leap_cur));

    assign dates.ready   = (state_reg == S_IDLE);
    assign results.valid = (state_reg == S_OUT);
    assign results.out_year    = oy_reg;
    assign results.out_month   = om_reg;
    assign results.out_day     = od_reg;
    assign results.day_of_year = doy_reg;
    assign results.status      = st_reg;

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        year_next  = year_reg;
        mon_next   = mon_reg;
        iy_next    = iy_reg;
        im_next    = im_reg;
        id_next    = id_reg;
        off_next   = off_reg;
        oy_next    = oy_reg;
        om_next    = om_reg;
        od_next    = od_reg;
        doy_next   = doy_reg;
        st_next    = st_reg;
        op_b       = '0;
        yctl       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (dates.valid)
                begin
                    iy_next    = dates.in_year;
                    im_next    = dates.in_month;
                    id_next    = dates.in_day;
                    off_next   = dates.offset;
                    year_next  = dates.in_year;
                    acc_next   = $signed({4'd0, dates.in_year});
                    state_next = S_MOD;
                end
            end

            // Reduce the year modulo 400 by repeated subtraction.
            S_MOD:
            begin
                op_b = -$signed({9'd0, YEAR_CYCLE});
                if (acc_reg >= $signed({9'd0, YEAR_CYCLE}))
                begin
                    acc_next = sum;
                end
                else
                begin
                    yctl.load     = 1'b1;
                    yctl.load_val = acc_reg[CYC_W-1:0];
                    state_next    = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (bad_date)
                begin
                    oy_next    = iy_reg;
                    om_next    = im_reg;
                    od_next    = id_reg;
                    doy_next   = '0;
                    st_next    = ST_BAD_DATE;
                    state_next = S_OUT;
                end
                else
                begin
                    // Clear the status left by the previous item before the walk.
                    st_next    = ST_OK;
                    acc_next   = $signed({13'd0, id_reg});
                    mon_next   = MONTH_FIRST;
                    state_next = S_DOY;
                end
            end

            // Add the lengths of the months before the start, then the offset.
            S_DOY:
            begin
                if (mon_reg < im_reg)
                begin
                    op_b     = $signed({13'd0, mlen});
                    acc_next = sum;
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    op_b       = $signed({off_reg[OFF_W-1], off_reg});
                    acc_next   = sum;
                    state_next = S_YEAR;
                end
            end

            // Walk whole years until the day count falls inside the working year, or stop with a range status.
            S_YEAR:
            begin
                priority if (acc_reg < $signed(18'sd1))
                begin
                    if (year_reg == YEAR_MIN)
                    begin
                        st_next    = ST_RANGE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        op_b      = ylen_prev;
                        acc_next  = sum;
                        year_next = year_reg - 14'd1;
                        yctl.dec  = 1'b1;
                    end
                end
                else if (acc_reg > ylen_cur)
                begin
                    if (year_reg == YEAR_MAX)
                    begin
                        st_next    = ST_RANGE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        op_b      = -ylen_cur;
                        acc_next  = sum;
                        year_next = year_reg + 14'd1;
                        yctl.inc  = 1'b1;
                    end
                end
                else
                begin
                    doy_next   = acc_reg[DOY_W-1:0];
                    mon_next   = MONTH_FIRST;
                    state_next = S_MON;
                end

                // An out-of-range result echoes the input date.
                if (st_next == ST_RANGE)
                begin
                    oy_next  = iy_reg;
                    om_next  = im_reg;
                    od_next  = id_reg;
                    doy_next = '0;
                end
            end

            // Peel off months until the remainder fits in the current one.
            S_MON:
            begin
                if ((mon_reg < MONTH_LAST) && (acc_reg > $signed({13'd0, mlen})))
                begin
                    op_b     = -$signed({13'd0, mlen});
                    acc_next = sum;
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    oy_next    = year_reg;
                    om_next    = mon_reg;
                    od_next    = acc_reg[DAY_W-1:0];
                    st_next    = ST_OK;
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (results.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        year_reg <= year_next;
        mon_reg  <= mon_next;
        iy_reg   <= iy_next;
        im_reg   <= im_next;
        id_reg   <= id_next;
        off_reg  <= off_next;
        oy_reg   <= oy_next;
        om_reg   <= om_next;
        od_reg   <= od_next;
        doy_reg  <= doy_next;
        st_reg   <= st_next;
    end

endmodule
